// ----- sv/utf8d_pkg.sv -----
// shared types and constants for the utf-8 stream decoder
`timescale 1ns / 1ps

package utf8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int PEND_W = 2;

    localparam logic [CP_W-1:0]   CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0]   CP_QUESTION    = 21'h00003F;

    localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7F;
    localparam logic [BYTE_W-1:0] CONT_MAX  = 8'hBF;
    localparam logic [BYTE_W-1:0] LEAD2_MAX = 8'hDF;
    localparam logic [BYTE_W-1:0] LEAD3_MAX = 8'hEF;
    localparam logic [BYTE_W-1:0] LEAD4_MAX = 8'hF7;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CP_W-1:0]   cp_t;

    typedef struct packed {
        logic emit;
        cp_t  cp;
    } dec_t;

endpackage

// ----- sv/utf8d_byte_if.sv -----
// byte channel interface: valid, ready and one raw byte
`timescale 1ns / 1ps

interface utf8d_byte_if;
    logic                        valid;
    logic                        ready;
    logic [utf8d_pkg::BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- sv/utf8d_cp_if.sv -----
// code point channel interface: valid, ready and one code point
`timescale 1ns / 1ps

interface utf8d_cp_if;
    logic                      valid;
    logic                      ready;
    logic [utf8d_pkg::CP_W-1:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

// ----- sv/utf8_stream_decoder_unit.sv -----
// top level of the utf-8 stream decoder
//
//  channel   dir   payload            width
//  raw       in    in_byte            8
//  decoded   out   code_point         21
//
// one byte per cycle sustained while decoded does not stall; a byte enters the input
// register, is decoded and lands in the output register
// bytes that only open or extend a sequence produce no item
// a stall on decoded holds the output register and backs up to raw.ready
// rst_n clears sequence state and both valid flags asynchronously
`timescale 1ns / 1ps

module utf8_stream_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    utf8d_byte_if.sink  raw,
    utf8d_cp_if.source  decoded
);
    import utf8d_pkg::*;

    logic  stage_valid;
    byte_t stage_data;
    logic  advance;
    logic  fire;
    dec_t  res;

    assign fire = stage_valid && advance;

    utf8d_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw),
        .advance (advance),
        .valid   (stage_valid),
        .data    (stage_data)
    );

    utf8d_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .data  (stage_data),
        .res   (res)
    );

    utf8d_out_stage u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (fire && res.emit),
        .cp      (res.cp),
        .advance (advance),
        .decoded (decoded)
    );

endmodule

// ----- sv/utf8d_in_stage.sv -----
// input register for raw bytes
`timescale 1ns / 1ps

module utf8d_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    utf8d_byte_if.sink      raw,
    input  logic            advance,
    output logic            valid,
    output utf8d_pkg::byte_t data
);
    import utf8d_pkg::*;

    logic  valid_reg;
    byte_t data_reg;

    // take a new byte when empty or when the held one moves on
    assign raw.ready = !valid_reg || advance;
    assign valid     = valid_reg;
    assign data      = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (raw.ready)
        begin
            valid_reg <= raw.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (raw.ready && raw.valid)
        begin
            data_reg <= raw.in_byte;
        end
    end

endmodule

// ----- sv/utf8d_core.sv -----
// decode state and per-byte decode logic
`timescale 1ns / 1ps

module utf8d_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  utf8d_pkg::byte_t data,
    output utf8d_pkg::dec_t  res
);
    import utf8d_pkg::*;

    logic [PEND_W-1:0] pending_reg, pending_next;
    cp_t               partial_reg, partial_next;
    logic              skip_reg, skip_next;
    cp_t               shifted;

    assign shifted = {partial_reg[CP_W-7:0], data[5:0]};

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        skip_next    = skip_reg;
        res.emit     = 1'b0;
        res.cp       = '0;
        if (pending_reg != PEND_NONE)
        begin
            // continuation bytes are taken unchecked
            pending_next = pending_reg - PEND_ONE;
            partial_next = shifted;
            if (pending_reg == PEND_ONE)
            begin
                res.emit     = 1'b1;
                res.cp       = shifted;
                partial_next = '0;
            end
        end
        else if (skip_reg && data[7:6] == 2'b10)
        begin
            // drop the tail after an invalid lead
        end
        else
        begin
            skip_next = 1'b0;
            priority if (data <= ASCII_MAX)
            begin
                res.emit = 1'b1;
                res.cp   = {{(CP_W-BYTE_W){1'b0}}, data};
            end
            else if (data <= CONT_MAX)
            begin
                res.emit = 1'b1;
                res.cp   = CP_QUESTION;
            end
            else if (data <= LEAD2_MAX)
            begin
                partial_next = {{(CP_W-5){1'b0}}, data[4:0]};
                pending_next = PEND_ONE;
            end
            else if (data <= LEAD3_MAX)
            begin
                partial_next = {{(CP_W-4){1'b0}}, data[3:0]};
                pending_next = PEND_TWO;
            end
            else if (data <= LEAD4_MAX)
            begin
                partial_next = {{(CP_W-3){1'b0}}, data[2:0]};
                pending_next = PEND_THREE;
            end
            else
            begin
                skip_next = 1'b1;
                res.emit  = 1'b1;
                res.cp    = CP_REPLACEMENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= PEND_NONE;
            partial_reg <= '0;
            skip_reg    <= 1'b0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            skip_reg    <= skip_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_skip_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        !(skip_reg && pending_reg != PEND_NONE))
        else $error("skipping while a sequence is open");

    a_last_cont_emits: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pending_reg == PEND_ONE |-> res.emit)
        else $error("last continuation byte gave no code point");

    a_bad_lead_skips: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pending_reg == PEND_NONE && data > LEAD4_MAX |=> skip_reg)
        else $error("invalid lead did not start skipping");

    a_lead_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pending_reg == PEND_NONE && data > CONT_MAX && data <= LEAD4_MAX
        |-> !res.emit)
        else $error("lead byte emitted a code point");
`endif

endmodule

// ----- sv/utf8d_out_stage.sv -----
// output register for decoded code points
`timescale 1ns / 1ps

module utf8d_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  utf8d_pkg::cp_t  cp,
    output logic            advance,
    utf8d_cp_if.source      decoded
);
    import utf8d_pkg::*;

    logic valid_reg;
    cp_t  cp_reg;

    // free when empty or when the held item is taken this cycle
    assign advance            = !valid_reg || decoded.ready;
    assign decoded.valid      = valid_reg;
    assign decoded.code_point = cp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (decoded.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cp_reg <= cp;
        end
    end

endmodule

// ----- tb/utf8_stream_decoder_unit_test.sv -----
// self-checking testbench for the utf-8 stream decoder top level
`timescale 1ns / 1ps

module utf8_stream_decoder_unit_test;
    import utf8d_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 10;
    localparam int BYTES_PER_PHASE = 213;
    localparam int NUM_PHASES     = 4;
    localparam int DRAIN_CYCLES   = 10;

    typedef struct {
        byte_t b;
        bit    pinned;
        bit    pin_emit;
        cp_t   pin_cp;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    utf8d_byte_if raw_bus ();
    utf8d_cp_if   decoded_bus ();

    utf8_stream_decoder_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .raw     (raw_bus),
        .decoded (decoded_bus)
    );

    // pinned rows carry a hand-read expectation, the rest go through the predictor
    stim_row_t dir_rows [26] = '{
        '{8'h00, 1'b1, 1'b1, 21'h000000},
        '{8'h7F, 1'b1, 1'b1, 21'h00007F},
        '{8'h80, 1'b1, 1'b1, CP_QUESTION},
        '{8'hBF, 1'b1, 1'b1, CP_QUESTION},
        '{8'hDF, 1'b0, 1'b0, 21'h0},
        '{8'hFF, 1'b0, 1'b0, 21'h0},
        '{8'hE0, 1'b0, 1'b0, 21'h0},
        '{8'h41, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hEF, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hF0, 1'b0, 1'b0, 21'h0},
        '{8'hF8, 1'b0, 1'b0, 21'h0},
        '{8'h00, 1'b0, 1'b0, 21'h0},
        '{8'hC0, 1'b0, 1'b0, 21'h0},
        '{8'hF7, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hBF, 1'b0, 1'b0, 21'h0},
        '{8'hF8, 1'b1, 1'b1, CP_REPLACEMENT},
        '{8'h80, 1'b1, 1'b0, 21'h0},
        '{8'hFF, 1'b1, 1'b1, CP_REPLACEMENT},
        '{8'hBF, 1'b1, 1'b0, 21'h0},
        '{8'hC0, 1'b0, 1'b0, 21'h0},
        '{8'h80, 1'b0, 1'b0, 21'h0}
    };

    // sender idle and receiver stall percentages per phase
    int send_pct_by_phase [NUM_PHASES] = '{0, 59, 0, 8};
    int recv_pct_by_phase [NUM_PHASES] = '{0, 0, 59, 8};

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int mismatch_count;

    cp_t pending_code_points [$];
    cp_t want_cp;

    // predictor copy of the decoder state
    logic [PEND_W-1:0] seq_left;
    cp_t               seq_bits;
    logic              dropping_tail;

    always #(CLK_HALF) clk = ~clk;

    function void decode_byte(input byte_t b, output logic emit, output cp_t cp);
        emit = 1'b0;
        cp   = '0;
        if (seq_left != PEND_NONE)
        begin
            // any byte counts as a continuation here, only its low six bits
            seq_bits = {seq_bits[CP_W-7:0], b[5:0]};
            seq_left = seq_left - PEND_ONE;
            if (seq_left == PEND_NONE)
            begin
                emit     = 1'b1;
                cp       = seq_bits;
                seq_bits = '0;
            end
        end
        else if (dropping_tail && b > ASCII_MAX && b <= CONT_MAX)
        begin
            // tail byte after an invalid lead is dropped
        end
        else
        begin
            dropping_tail = 1'b0;
            if (b <= ASCII_MAX)
            begin
                emit = 1'b1;
                cp   = cp_t'(b);
            end
            else if (b <= CONT_MAX)
            begin
                emit = 1'b1;
                cp   = CP_QUESTION;
            end
            else if (b <= LEAD2_MAX)
            begin
                seq_bits = cp_t'(b[4:0]);
                seq_left = PEND_ONE;
            end
            else if (b <= LEAD3_MAX)
            begin
                seq_bits = cp_t'(b[3:0]);
                seq_left = PEND_TWO;
            end
            else if (b <= LEAD4_MAX)
            begin
                seq_bits = cp_t'(b[2:0]);
                seq_left = PEND_THREE;
            end
            else
            begin
                dropping_tail = 1'b1;
                emit          = 1'b1;
                cp            = CP_REPLACEMENT;
            end
        end
    endfunction

    function byte_t rand_in(input int lo, input int hi);
        return byte_t'($urandom_range(hi, lo));
    endfunction

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_byte(input byte_t b, input bit pinned, input bit pin_emit,
                             input cp_t pin_cp);
        logic emit;
        cp_t  cp;
        if ($urandom_range(99) < send_idle_pct)
        begin
            raw_bus.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        raw_bus.valid   <= 1'b1;
        raw_bus.in_byte <= b;
        do
            @(posedge clk);
        while (!raw_bus.ready);
        decode_byte(b, emit, cp);
        if (pinned)
        begin
            emit = pin_emit;
            cp   = pin_cp;
        end
        if (emit)
            pending_code_points.push_back(cp);
        bytes_sent++;
    endtask

    // mostly well-formed sequences with random payload, plus strays and broken ones
    task automatic send_random_symbol();
        byte_t seq [$];
        int    kind;
        int    n;
        kind = $urandom_range(99);
        if (kind < 20)
        begin
            seq.push_back(rand_in(8'h00, 8'h7F));
        end
        else if (kind < 38)
        begin
            seq.push_back(rand_in(8'hC0, 8'hDF));
            seq.push_back(rand_in(8'h80, 8'hBF));
        end
        else if (kind < 53)
        begin
            seq.push_back(rand_in(8'hE0, 8'hEF));
            repeat (2) seq.push_back(rand_in(8'h80, 8'hBF));
        end
        else if (kind < 66)
        begin
            seq.push_back(rand_in(8'hF0, 8'hF7));
            repeat (3) seq.push_back(rand_in(8'h80, 8'hBF));
        end
        else if (kind < 73)
        begin
            seq.push_back(rand_in(8'h80, 8'hBF));
        end
        else if (kind < 84)
        begin
            seq.push_back(rand_in(8'hF8, 8'hFF));
            n = $urandom_range(3);
            repeat (n) seq.push_back(rand_in(8'h80, 8'hBF));
        end
        else if (kind < 92)
        begin
            seq.push_back(rand_in(8'hC0, 8'hF7));
            n = $urandom_range(3);
            repeat (n) seq.push_back(rand_in(8'h00, 8'hFF));
        end
        else
        begin
            seq.push_back(rand_in(8'h00, 8'hFF));
        end
        foreach (seq[i])
            send_byte(seq[i], 1'b0, 1'b0, '0);
    endtask

    always @(posedge clk)
        decoded_bus.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (decoded_bus.valid && decoded_bus.ready)
        begin
            if (pending_code_points.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, got code point %h",
                         $time, decoded_bus.code_point);
                mismatch_count++;
            end
            else
            begin
                want_cp = pending_code_points.pop_front();
                if (decoded_bus.code_point !== want_cp)
                begin
                    $display("%0t: code point mismatch, expected %h, got %h",
                             $time, want_cp, decoded_bus.code_point);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        raw_bus.valid     <= 1'b0;
        raw_bus.in_byte   <= '0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        bytes_sent        = 0;
        mismatch_count    = 0;
        seq_left          = PEND_NONE;
        seq_bits          = '0;
        dropping_tail     = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].b, dir_rows[i].pinned, dir_rows[i].pin_emit,
                      dir_rows[i].pin_cp);

        bytes_sent = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            send_idle_pct  = send_pct_by_phase[phase];
            recv_stall_pct = recv_pct_by_phase[phase];
            while (bytes_sent < (phase + 1) * BYTES_PER_PHASE)
                send_random_symbol();
        end

        raw_bus.valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_code_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #(2 * CLK_HALF * 200000);
        $display("Verification failed");
        $finish;
    end

endmodule
